[rtl/core/trq_pkg.sv]
// Package for the task ring queue: widths, command codes and the
// controller/datapath command and status structs. No dependencies.
package trq_pkg;

    // Fixed field widths of the channels.
    localparam int CMD_W   = 2;
    localparam int TASK_W  = 16;
    localparam int LEVEL_W = 3;

    // Defaults for the top-level parameters.
    localparam int RING_DEPTH_DEF = 64;
    localparam int TASK_BITS_DEF  = 16;

    // Command codes on the request channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_GRAB = 2'd2
    } cmd_t;

    // Source of the next result loaded into the output register.
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_TASK,
        SRC_EMPTY
    } emit_src_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STREAM,
        ST_TASK,
        ST_EMPTY
    } trq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      put_write;
        logic      start;
        logic      start_ovf;
        logic      advance;
        logic      emit;
        emit_src_t src;
    } trq_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic remain_zero;
        logic ovf;
        logic out_free;
    } trq_sts_t;

endpackage

[rtl/core/trq_req_if.sv]
// Request channel interface: valid/ready handshake with command and task.
// Depends on trq_pkg for field widths.
interface trq_req_if
    import trq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [TASK_W-1:0]   task_id;

    modport source (output valid, output cmd, output task_id, input ready);
    modport sink   (input valid, input cmd, input task_id, output ready);
endinterface

[rtl/core/trq_rsp_if.sv]
// Response channel interface: valid/ready handshake with one result.
// Depends on trq_pkg for field widths.
interface trq_rsp_if
    import trq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   task_out;
    logic                found;
    logic                to_global;
    logic [LEVEL_W-1:0]  level;
    logic                last;

    modport source (output valid, output task_out, output found, output to_global,
                    output level, output last, input ready);
    modport sink   (input valid, input task_out, input found, input to_global,
                    input level, input last, output ready);
endinterface

[rtl/core/trq_ctrl.sv]
// Controller state machine for the task ring queue.
// Depends on trq_pkg for the state type and the command/status structs.
module trq_ctrl
    import trq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             req_ready,
    input  trq_sts_t         sts,
    output trq_ctl_t         ctl
);

    trq_state_t state_reg;
    trq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_cmd == CMD_PUT)
                    begin
                        if (sts.full)
                        begin
                            state_next = ST_STREAM;
                        end
                    end
                    else if (req_cmd == CMD_GET || req_cmd == CMD_GRAB)
                    begin
                        state_next = sts.empty ? ST_EMPTY : ST_STREAM;
                    end
                end
            end
            ST_STREAM:
            begin
                if (sts.out_free && sts.remain_zero)
                begin
                    state_next = sts.ovf ? ST_TASK : ST_IDLE;
                end
            end
            ST_TASK, ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake ready and datapath commands.
    always_comb
    begin
        req_ready     = 1'b0;
        ctl.put_write = 1'b0;
        ctl.start     = 1'b0;
        ctl.start_ovf = 1'b0;
        ctl.advance   = 1'b0;
        ctl.emit      = 1'b0;
        ctl.src       = SRC_MEM;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_cmd == CMD_PUT)
                    begin
                        ctl.put_write = !sts.full;
                        ctl.start     = sts.full;
                        ctl.start_ovf = sts.full;
                    end
                    else if (req_cmd == CMD_GET || req_cmd == CMD_GRAB)
                    begin
                        ctl.start = !sts.empty;
                    end
                end
            end
            ST_STREAM:
            begin
                ctl.src     = SRC_MEM;
                ctl.emit    = sts.out_free;
                ctl.advance = sts.out_free && !sts.remain_zero;
            end
            ST_TASK:
            begin
                ctl.src  = SRC_TASK;
                ctl.emit = sts.out_free;
            end
            ST_EMPTY:
            begin
                ctl.src  = SRC_EMPTY;
                ctl.emit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/trq_dpath.sv]
// Datapath for the task ring queue: ring memory, pointers, run counter,
// level register and output register. Depends on trq_pkg.
module trq_dpath
    import trq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TASK_BITS  = TASK_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CMD_W-1:0]   req_cmd,
    input  logic [TASK_W-1:0]  req_task_id,
    input  logic               cfg_we,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    input  trq_ctl_t           ctl,
    output trq_sts_t           sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TASK_W-1:0]  out_task,
    output logic               out_found,
    output logic               out_global,
    output logic [LEVEL_W-1:0] out_level,
    output logic               out_last
);

    // Stored task width never exceeds the channel field.
    localparam int STORE_W = (TASK_BITS < TASK_W) ? TASK_BITS : TASK_W;
    localparam int PTR_W   = $clog2(2 * RING_DEPTH);
    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_DEPTH - 1);
    localparam logic [PTR_W:0]   PTR_MODV  = (PTR_W + 1)'(2 * RING_DEPTH);
    localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] HALF_M1   = CNT_W'(RING_DEPTH / 2 - 1);

    logic [STORE_W-1:0] mem [RING_DEPTH];

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               ovf_reg;
    logic [STORE_W-1:0] task_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [STORE_W-1:0] rd_data_reg;

    logic               out_valid_reg;
    logic [TASK_W-1:0]  out_task_reg;
    logic               out_found_reg;
    logic               out_global_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_last_reg;

    logic [PTR_W:0]     diff;
    logic [CNT_W-1:0]   fill;
    logic [CNT_W-1:0]   grab_n;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic [STORE_W-1:0] task_in;
    logic               rd_en;
    logic               out_free;
    logic               emit_global;

    // Fill level from the pointers, which count modulo twice the depth.
    always_comb
    begin
        diff = {1'b0, tail_reg} - {1'b0, head_reg};
        if (tail_reg < head_reg)
        begin
            diff = diff + PTR_MODV;
        end
        fill   = CNT_W'(diff);
        grab_n = fill - (fill >> 1);
    end

    // Slot addresses: pointer folded into the ring.
    assign head_slot = (head_reg >= DEPTH_P) ? SLOT_W'(head_reg - DEPTH_P) : SLOT_W'(head_reg);
    assign tail_slot = (tail_reg >= DEPTH_P) ? SLOT_W'(tail_reg - DEPTH_P) : SLOT_W'(tail_reg);
    assign task_in   = STORE_W'(req_task_id);
    assign rd_en     = ctl.start || ctl.advance;
    assign out_free  = !out_valid_reg || out_ready;

    // Pointer and run counter updates.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        remain_next = remain_reg;
        if (rd_en)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (ctl.put_write)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.start)
        begin
            if (ctl.start_ovf)
            begin
                remain_next = HALF_M1;
            end
            else if (req_cmd == CMD_GRAB)
            begin
                remain_next = grab_n - 1'b1;
            end
            else
            begin
                remain_next = '0;
            end
        end
        else if (ctl.advance)
        begin
            remain_next = remain_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            remain_reg    <= '0;
            ovf_reg       <= 1'b0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            remain_reg <= remain_next;
            if (ctl.start)
            begin
                ovf_reg <= ctl.start_ovf;
            end
            if (cfg_we)
            begin
                level_reg <= cfg_wdata;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ring memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.put_write)
        begin
            mem[tail_slot] <= task_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_slot];
        end
        if (ctl.start)
        begin
            task_reg <= task_in;
        end
    end

    // Output payload register.
    assign emit_global = (ctl.src == SRC_TASK) || (ctl.src == SRC_MEM && ovf_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_global_reg <= emit_global;
            out_level_reg  <= emit_global ? level_reg : '0;
            case (ctl.src)
                SRC_MEM:
                begin
                    out_task_reg  <= TASK_W'(rd_data_reg);
                    out_found_reg <= 1'b1;
                    out_last_reg  <= (remain_reg == '0) && !ovf_reg;
                end
                SRC_TASK:
                begin
                    out_task_reg  <= TASK_W'(task_reg);
                    out_found_reg <= 1'b1;
                    out_last_reg  <= 1'b1;
                end
                default:
                begin
                    out_task_reg  <= '0;
                    out_found_reg <= 1'b0;
                    out_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    // Status toward the controller.
    assign sts.empty       = (fill == '0);
    assign sts.full        = (fill == DEPTH_C);
    assign sts.remain_zero = (remain_reg == '0);
    assign sts.ovf         = ovf_reg;
    assign sts.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign out_task   = out_task_reg;
    assign out_found  = out_found_reg;
    assign out_global = out_global_reg;
    assign out_level  = out_level_reg;
    assign out_last   = out_last_reg;

endmodule

[rtl/core/task_ring_queue_with_half_steal.sv]
// Top level of the task ring queue with half steal.
// Depends on trq_pkg, trq_req_if, trq_rsp_if, trq_ctrl and trq_dpath.

// A per-worker run queue of task identifiers in a ring of RING_DEPTH entries,
// held in a single-port memory with a registered read. A put into a ring that
// is not full is written into the ring and gives no result. A get is accepted
// and its result is loaded after the memory read; the block stays busy until
// that load. A grab of n tasks, or an overflowing put with RING_DEPTH/2 + 1
// results, is accepted and then streams one result per cycle while the result
// channel is free, with the next read overlapping the current output load.
// Back pressure on the result channel stretches these runs. Get or grab on an
// empty ring answers with found low on the same timing as a get: the result is
// loaded once the output register is free, and the block stays busy until
// then. The block handles one command at a time; the result register lets it
// accept the next command while the last result is still waiting to be taken.
module task_ring_queue_with_half_steal
    import trq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TASK_BITS  = TASK_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    trq_req_if.sink            req,
    trq_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [LEVEL_W-1:0] cfg_wdata
);

    trq_ctl_t ctl;
    trq_sts_t sts;

    // Controller.
    trq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Datapath.
    trq_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .TASK_BITS  (TASK_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_cmd     (req.cmd),
        .req_task_id (req.task_id),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ctl         (ctl),
        .sts         (sts),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_task    (rsp.task_out),
        .out_found   (rsp.found),
        .out_global  (rsp.to_global),
        .out_level   (rsp.level),
        .out_last    (rsp.last)
    );

`ifndef ASSERT_OFF
    // The fill level can never be empty and full at once.
    a_fill_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.empty && sts.full))
        else $error("ring reports empty and full together");

    // An accepted get or grab always makes the block busy in the next cycle.
    a_busy_after_get: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.cmd == CMD_GET || req.cmd == CMD_GRAB))
        |=> !req.ready)
        else $error("request accepted right after get or grab");

    // An empty answer is a single caller item.
    a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.last && !rsp.to_global))
        else $error("empty answer is not a final caller item");

    // Items for the caller carry level zero.
    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.to_global) |-> (rsp.level == '0))
        else $error("caller item carries a nonzero level");
`endif

endmodule
